[hdl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
// Depends on nothing; each macro takes a clock, a reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/s3cpu_pkg.sv]
// Shared types, codes and constants of the three-operand CPU block.
// Depends on nothing; front end, back end and top use scoped names, the testbench files import it.
package s3cpu_pkg;

  localparam int MEM_WORDS_DEF = 65536;
  localparam logic [3:0] LINK_REG = 4'd11;
  localparam logic [3:0] PC_REG   = 4'd12;
  localparam logic [3:0] IMM_REG  = 4'd15;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  reg_index;
  } in_t;

  typedef struct packed {
    logic               halted;
    logic               printed;
    logic signed [15:0] print_value;
    logic signed [15:0] read_value;
    logic [15:0]        pc;
    logic               div_zero;
  } out_t;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'h0, OP_SUB = 4'h1, OP_MUL = 4'h2, OP_DIV = 4'h3,
    OP_SHL = 4'h4, OP_SAR = 4'h5, OP_LOAD = 4'h6, OP_STORE = 4'h7,
    OP_XOR = 4'h8, OP_OR = 4'h9, OP_AND = 4'ha, OP_BNZ = 4'hb,
    OP_LT = 4'hc, OP_LE = 4'hd, OP_EQ = 4'he, OP_PRINT = 4'hf
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDOUT, S_DECODE, S_IMM, S_RDA, S_RDB,
    S_EXEC, S_MEM, S_DIV, S_COMMIT
  } state_t;

  // Head of the item queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } head_t;

  // Control from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic logic [15:0] reg_reset(input logic [3:0] idx);
    logic [15:0] v;
    v = 16'h0000;
    if (idx == 4'd9) v = 16'hffff;
    if (idx == LINK_REG || idx == 4'd13) v = 16'd2048;
    if (idx == PC_REG) v = 16'h0001;
    return v;
  endfunction

endpackage

[hdl/s3cpu_front.sv]
// Front end: a two-entry queue that accepts items and tags each with its kind.
// Depends on s3cpu_pkg.
module s3cpu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  s3cpu_pkg::in_t       item,
  input  s3cpu_pkg::back_ctl_t ctl,
  output s3cpu_pkg::head_t     head,
  output s3cpu_pkg::in_t       head_item
);

  s3cpu_pkg::in_t   q_item [2];
  s3cpu_pkg::kind_t q_kind [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2) || ctl.clearing;
  assign do_push = push && !full;
  assign do_pop  = ctl.pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_item[wr_ptr] <= item;
      q_kind[wr_ptr] <= s3cpu_pkg::kind_t'(item.action);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.kind  = q_kind[rd_ptr];
  assign head_item  = q_item[rd_ptr];

endmodule

[hdl/s3cpu_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; the caller handles a zero divisor.
module s3cpu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [16:0] q;
  logic [16:0] rem;
  logic [16:0] mag_b;
  logic        neg;
  logic [17:0] trial;
  logic [16:0] rem_sh;

  assign rem_sh = {rem[15:0], q[16]};
  assign trial  = {1'b0, rem_sh} - {1'b0, mag_b};
  assign done   = busy && (cnt == 5'd0);
  assign quotient = neg ? 16'(~q + 17'd1) : q[15:0];

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[15] ? (~{1'b1, dividend} + 17'd1) : {1'b0, dividend};
      mag_b <= divisor[15] ? (~{1'b1, divisor} + 17'd1) : {1'b0, divisor};
      neg   <= dividend[15] ^ divisor[15];
      rem   <= 17'd0;
    end else if (busy && cnt != 5'd0) begin
      if (!trial[17]) begin
        rem <= trial[16:0];
        q   <= {q[15:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd17;
    end else if (busy) begin
      if (cnt == 5'd0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end

endmodule

[hdl/s3cpu_exec.sv]
// Back end: sequencer, register file, word memory and result assembly.
// Depends on s3cpu_pkg and s3cpu_div.
module s3cpu_exec #(
  parameter int MEM_WORDS = s3cpu_pkg::MEM_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  s3cpu_pkg::head_t     head,
  input  s3cpu_pkg::in_t       head_item,
  input  logic                 slot_busy,
  output s3cpu_pkg::back_ctl_t ctl,
  output logic                 res_valid,
  output s3cpu_pkg::out_t      res
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [22:0] MW = 23'(MEM_WORDS);

  function automatic logic [AW-1:0] maddr(input logic [15:0] a);
    logic [22:0] v;
    v = {7'd0, a};
    for (int k = 5; k >= 0; k--) begin
      if (v >= (MW << k)) v = v - (MW << k);
    end
    return v[AW-1:0];
  endfunction

  s3cpu_pkg::state_t st, st_next;

  logic [15:0]   mem [MEM_WORDS];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;
  logic [AW-1:0] clr_addr;

  logic [15:0] rf_mem [16];
  logic [15:0] rf_vld;
  logic [3:0]  rd0_idx, rd1_idx;
  logic [15:0] rd0, rd1;
  logic        rf_we;
  logic [3:0]  rf_widx;
  logic [15:0] rf_wdata;

  logic [15:0] pc;
  logic        halt;
  logic [15:0] ins;
  logic        imm;
  logic [15:0] a, b;
  logic [15:0] res_val;
  logic        dz;
  logic        wr;
  logic        br_taken;
  logic [15:0] br_tgt;
  logic        printed;
  logic [15:0] pval;

  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;

  s3cpu_pkg::op_t op;
  logic [3:0]  fx, fy, fz;
  logic [15:0] sum;
  logic [31:0] prod;
  logic [15:0] alu;
  logic [15:0] pc_new;
  logic [15:0] pc_base;

  assign op  = s3cpu_pkg::op_t'(ins[15:12]);
  assign fx  = ins[11:8];
  assign fy  = ins[7:4];
  assign fz  = ins[3:0];
  assign sum = a + b;
  assign prod = a * b;

  always_comb begin
    alu = 16'h0000;
    case (op)
      s3cpu_pkg::OP_ADD: alu = sum;
      s3cpu_pkg::OP_SUB: alu = a - b;
      s3cpu_pkg::OP_MUL: alu = prod[15:0];
      s3cpu_pkg::OP_SHL: alu = (b >= 16'd16) ? 16'h0000 : (a << b[3:0]);
      s3cpu_pkg::OP_SAR: alu = (b >= 16'd16) ? {16{a[15]}} : 16'($signed(a) >>> b[3:0]);
      s3cpu_pkg::OP_XOR: alu = a ^ b;
      s3cpu_pkg::OP_OR:  alu = a | b;
      s3cpu_pkg::OP_AND: alu = a & b;
      s3cpu_pkg::OP_LT:  alu = {15'd0, $signed(a) < $signed(b)};
      s3cpu_pkg::OP_LE:  alu = {15'd0, $signed(a) <= $signed(b)};
      s3cpu_pkg::OP_EQ:  alu = {15'd0, a == b};
      default:           alu = 16'h0000;
    endcase
  end

  s3cpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Word memory, one port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  // Register file with two registered read ports; r12 lives in pc.
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_widx] <= rf_wdata;
    if (rd0_idx == s3cpu_pkg::PC_REG) rd0 <= pc;
    else if (rf_vld[rd0_idx]) rd0 <= rf_mem[rd0_idx];
    else rd0 <= s3cpu_pkg::reg_reset(rd0_idx);
    if (rd1_idx == s3cpu_pkg::PC_REG) rd1 <= pc;
    else if (rf_vld[rd1_idx]) rd1 <= rf_mem[rd1_idx];
    else rd1 <= s3cpu_pkg::reg_reset(rd1_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) rf_vld <= 16'h0000;
    else if (rf_we) rf_vld[rf_widx] <= 1'b1;
  end

  assign pc_base = (wr && fx == s3cpu_pkg::PC_REG) ? res_val : pc;
  assign pc_new  = (op == s3cpu_pkg::OP_BNZ && br_taken) ? br_tgt
                 : pc_base + (imm ? 16'd2 : 16'd1);

  always_comb begin
    st_next      = st;
    ctl.pop      = 1'b0;
    ctl.clearing = (st == s3cpu_pkg::S_CLEAR);
    mem_addr     = maddr(pc);
    mem_we       = 1'b0;
    mem_wdata    = 16'h0000;
    rd0_idx      = head_item.reg_index;
    rd1_idx      = fz;
    rf_we        = 1'b0;
    rf_widx      = fx;
    rf_wdata     = res_val;
    div_start    = 1'b0;
    res_valid    = 1'b0;
    res.halted      = halt;
    res.printed     = 1'b0;
    res.print_value = 16'sd0;
    res.read_value  = 16'sd0;
    res.pc          = pc;
    res.div_zero    = 1'b0;
    unique case (st)
      s3cpu_pkg::S_CLEAR: begin
        mem_addr = clr_addr;
        mem_we   = 1'b1;
        if (clr_addr == AW'(MEM_WORDS - 1)) st_next = s3cpu_pkg::S_IDLE;
      end
      s3cpu_pkg::S_IDLE: begin
        if (head.valid && !slot_busy) begin
          ctl.pop = 1'b1;
          unique case (head.kind)
            s3cpu_pkg::ACT_WRITE: begin
              mem_addr  = maddr(head_item.address);
              mem_we    = 1'b1;
              mem_wdata = head_item.data;
              res_valid = 1'b1;
            end
            s3cpu_pkg::ACT_READ: st_next = s3cpu_pkg::S_RDOUT;
            s3cpu_pkg::ACT_EXEC: begin
              if (halt) res_valid = 1'b1;
              else st_next = s3cpu_pkg::S_DECODE;
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      s3cpu_pkg::S_RDOUT: begin
        res_valid      = 1'b1;
        res.read_value = rd0;
        st_next        = s3cpu_pkg::S_IDLE;
      end
      s3cpu_pkg::S_DECODE: begin
        mem_addr = maddr(pc + 16'd1);
        if (mem_rdata[11:8] == 4'hf || mem_rdata[7:4] == 4'hf || mem_rdata[3:0] == 4'hf)
          st_next = s3cpu_pkg::S_IMM;
        else
          st_next = s3cpu_pkg::S_RDA;
      end
      s3cpu_pkg::S_IMM: begin
        rf_we    = 1'b1;
        rf_widx  = s3cpu_pkg::IMM_REG;
        rf_wdata = mem_rdata;
        st_next  = s3cpu_pkg::S_RDA;
      end
      s3cpu_pkg::S_RDA: begin
        rd0_idx = fy;
        rd1_idx = fz;
        st_next = s3cpu_pkg::S_RDB;
      end
      s3cpu_pkg::S_RDB: begin
        rd0_idx = fx;
        st_next = s3cpu_pkg::S_EXEC;
      end
      s3cpu_pkg::S_EXEC: begin
        mem_addr = maddr(sum);
        st_next  = s3cpu_pkg::S_COMMIT;
        case (op)
          s3cpu_pkg::OP_DIV: begin
            if (b != 16'h0000) begin
              div_start = 1'b1;
              st_next   = s3cpu_pkg::S_DIV;
            end
          end
          s3cpu_pkg::OP_LOAD, s3cpu_pkg::OP_PRINT: st_next = s3cpu_pkg::S_MEM;
          s3cpu_pkg::OP_STORE: begin
            mem_we    = 1'b1;
            mem_wdata = rd0;
          end
          default: ;
        endcase
      end
      s3cpu_pkg::S_MEM: st_next = s3cpu_pkg::S_COMMIT;
      s3cpu_pkg::S_DIV: if (div_done) st_next = s3cpu_pkg::S_COMMIT;
      s3cpu_pkg::S_COMMIT: begin
        if (op == s3cpu_pkg::OP_BNZ) begin
          rf_we    = br_taken;
          rf_widx  = s3cpu_pkg::LINK_REG;
          rf_wdata = pc;
        end else begin
          rf_we = wr && (fx != s3cpu_pkg::PC_REG);
        end
        res_valid       = 1'b1;
        res.halted      = halt || (pc_new == 16'h0000);
        res.printed     = printed;
        res.print_value = pval;
        res.pc          = pc_new;
        res.div_zero    = dz;
        st_next         = s3cpu_pkg::S_IDLE;
      end
      default: st_next = s3cpu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st)
      s3cpu_pkg::S_DECODE: begin
        ins <= mem_rdata;
        imm <= (mem_rdata[11:8] == 4'hf) || (mem_rdata[7:4] == 4'hf)
               || (mem_rdata[3:0] == 4'hf);
        printed <= 1'b0;
        pval    <= 16'h0000;
        dz      <= 1'b0;
      end
      s3cpu_pkg::S_RDB: begin
        a <= rd0;
        b <= rd1;
      end
      s3cpu_pkg::S_EXEC: begin
        res_val  <= alu;
        wr       <= !(op == s3cpu_pkg::OP_STORE || op == s3cpu_pkg::OP_BNZ
                      || op == s3cpu_pkg::OP_PRINT);
        br_taken <= (rd0 != 16'h0000);
        br_tgt   <= sum;
        if (op == s3cpu_pkg::OP_DIV && b == 16'h0000) begin
          res_val <= 16'hffff;
          dz      <= 1'b1;
        end
      end
      s3cpu_pkg::S_MEM: begin
        if (op == s3cpu_pkg::OP_PRINT) begin
          printed <= 1'b1;
          pval    <= mem_rdata;
        end else begin
          res_val <= mem_rdata;
        end
      end
      s3cpu_pkg::S_DIV: if (div_done) res_val <= div_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= s3cpu_pkg::S_CLEAR;
      clr_addr <= '0;
      pc       <= s3cpu_pkg::reg_reset(s3cpu_pkg::PC_REG);
      halt     <= 1'b0;
    end else begin
      st <= st_next;
      if (st == s3cpu_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (st == s3cpu_pkg::S_COMMIT) begin
        pc <= pc_new;
        if (pc_new == 16'h0000) halt <= 1'b1;
      end
    end
  end

endmodule

[hdl/sixteen_bit_three_operand_cpu.sv]
// One item runs at a time. A memory write, an idle slot or a halted step is answered in
// the idle state, a register read in a read-out state; an instruction passes decode, an
// immediate fetch if needed, operand reads, execute, a memory or divide step if any, commit.
// Fetch, immediate and data share the single-port word memory. Reset is synchronous; then
// a clearing pass over all MEM_WORDS words zeroes it, and full stays high until it ends.
module sixteen_bit_three_operand_cpu #(
  parameter int MEM_WORDS = s3cpu_pkg::MEM_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  s3cpu_pkg::in_t  item,
  output logic            empty,
  input  logic            pop,
  output s3cpu_pkg::out_t result
);
`include "assert_macros.svh"

  // The front end queues items so that the host can keep pushing while the
  // back end is busy or a result still waits to be popped.
  s3cpu_pkg::head_t     head;
  s3cpu_pkg::in_t       head_item;
  s3cpu_pkg::back_ctl_t ctl;

  // One result word is held here until it is popped.
  logic            res_valid;
  s3cpu_pkg::out_t res;
  logic            out_valid;
  s3cpu_pkg::out_t out_word;

  s3cpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .ctl       (ctl),
    .head      (head),
    .head_item (head_item)
  );

  // The back end only starts an item while the result slot is free, so a
  // finished word can never overwrite one that has not been taken.
  s3cpu_exec #(
    .MEM_WORDS (MEM_WORDS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_item (head_item),
    .slot_busy (out_valid),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (res_valid) out_word <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_valid) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  assign empty  = !out_valid;
  assign result = out_word;

  // No result is produced into an occupied slot.
  `ASSERT_SAME(a_slot_free, clk, rst, res_valid, !out_valid)
  // While memory is being cleared, nothing can be pushed.
  `ASSERT_SAME(a_clear_blocks, clk, rst, ctl.clearing, full)
  // A halted core always reports a program counter of zero.
  `ASSERT_SAME(a_halt_pc, clk, rst, !empty && result.halted, result.pc == 16'h0000)
  // A popped word leaves the slot empty unless a new one arrives.
  `ASSERT_NEXT(a_pop_clears, clk, rst, pop && !empty && !res_valid, empty)

endmodule

[tb/sv/s3cpu_scoreboard.sv]
// Checker for the three-operand CPU: watches both word channels, predicts each result
// from its own copy of the registers and word memory, and compares. Depends on s3cpu_pkg.
module s3cpu_scoreboard (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            full,
  input  s3cpu_pkg::in_t  item,
  input  logic            empty,
  input  logic            pop,
  input  s3cpu_pkg::out_t result,
  output int              errors,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import s3cpu_pkg::*;

  logic [15:0] regs [16];
  logic [15:0] mem [65536];
  bit          halted_q;
  out_t        expected_results[$];

  function automatic logic [15:0] sar16(input logic [15:0] v, input logic [15:0] c);
    if (c >= 16) return v[15] ? 16'hffff : 16'h0000;
    return $signed(v) >>> c;
  endfunction

  // Applies one word to the shadow machine and returns what the core should report.
  task automatic run_word(input in_t w, output out_t o);
    logic [15:0] pc, ins, a, b, r, inc;
    op_t         op;
    logic [3:0]  x, y, z;
    bit          wr;
    o = '0;
    if (w.action == ACT_WRITE) begin
      mem[w.address] = w.data;
    end else if (w.action == ACT_READ) begin
      o.read_value = regs[w.reg_index];
    end else if (w.action == ACT_EXEC && !halted_q) begin
      pc = regs[PC_REG];
      ins = mem[pc];
      op = op_t'(ins[15:12]);
      x = ins[11:8];
      y = ins[7:4];
      z = ins[3:0];
      inc = 16'd1;
      r = '0;
      wr = 1;
      // Any field naming r15 pulls the following word in as an immediate.
      if (x == IMM_REG || y == IMM_REG || z == IMM_REG) begin
        inc = 16'd2;
        regs[IMM_REG] = mem[16'(pc + 16'd1)];
      end
      a = regs[y];
      b = regs[z];
      case (op)
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = a * b;
        OP_DIV: begin
          if (b == 0) begin
            r = 16'hffff;
            o.div_zero = 1'b1;
          end else begin
            r = 16'(int'($signed(a)) / int'($signed(b)));
          end
        end
        OP_SHL: r = (b >= 16) ? 16'h0000 : 16'(a << b);
        OP_SAR: r = sar16(a, b);
        OP_LOAD: r = mem[16'(a + b)];
        OP_STORE: begin
          mem[16'(a + b)] = regs[x];
          wr = 0;
        end
        OP_XOR: r = a ^ b;
        OP_OR:  r = a | b;
        OP_AND: r = a & b;
        OP_BNZ: wr = 0;
        OP_LT:  r = ($signed(a) < $signed(b)) ? 16'd1 : 16'd0;
        OP_LE:  r = ($signed(a) <= $signed(b)) ? 16'd1 : 16'd0;
        OP_EQ:  r = (a == b) ? 16'd1 : 16'd0;
        default: begin
          o.printed = 1'b1;
          o.print_value = mem[16'(a + b)];
          wr = 0;
        end
      endcase
      if (op == OP_BNZ) begin
        if (regs[x] != 0) begin
          regs[LINK_REG] = regs[PC_REG];
          regs[PC_REG] = a + b;
        end else begin
          regs[PC_REG] = regs[PC_REG] + inc;
        end
      end else begin
        if (wr) regs[x] = r;
        // A write to the program counter is still followed by the advance.
        regs[PC_REG] = regs[PC_REG] + inc;
      end
      if (regs[PC_REG] == 0) halted_q = 1;
    end
    o.halted = halted_q;
    o.pc = regs[PC_REG];
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_t o, e;
    if (rst) begin
      errors <= 0;
      pending <= 0;
      expected_results.delete();
      for (int i = 0; i < 16; i++) regs[i] = '0;
      regs[9] = 16'hffff;
      regs[LINK_REG] = 16'd2048;
      regs[13] = 16'd2048;
      regs[PC_REG] = 16'd1;
      for (int i = 0; i < 65536; i++) mem[i] = '0;
      halted_q = 0;
    end else begin
      if (push && !full) begin
        run_word(item, o);
        expected_results.push_back(o);
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, actual %h", $realtime, result);
        end else begin
          e = expected_results.pop_front();
          check_field("halted", 16'(e.halted), 16'(result.halted));
          check_field("printed", 16'(e.printed), 16'(result.printed));
          check_field("print_value", e.print_value, result.print_value);
          check_field("read_value", e.read_value, result.read_value);
          check_field("pc", e.pc, result.pc);
          check_field("div_zero", 16'(e.div_zero), 16'(result.div_zero));
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

[tb/sv/sixteen_bit_three_operand_cpu_tb.sv]
// Top of the CPU testbench: clock, reset, stimulus words and the verdict.
// Depends on s3cpu_pkg, the CPU block and the s3cpu_scoreboard checker.
module sixteen_bit_three_operand_cpu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s3cpu_pkg::*;

  logic clk, rst, push, full, empty, pop;
  in_t  item;
  out_t result;
  int   errors, pending;

  // Handshake bookkeeping used only to pace the stimulus.
  int          words_sent, words_pushed, words_popped;
  logic [15:0] last_pc;
  int          send_idle, recv_idle;
  int          hold_ticket, hold_seen, hold_left;

  sixteen_bit_three_operand_cpu DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  s3cpu_scoreboard checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Count accepted words on both sides and remember the last reported PC,
  // which the stimulus needs to know where the next instruction must go.
  always @(posedge clk) begin
    if (rst) begin
      words_pushed <= 0;
      words_popped <= 0;
      last_pc <= 16'd1;
    end else begin
      if (push && !full) words_pushed <= words_pushed + 1;
      if (pop && !empty) begin
        words_popped <= words_popped + 1;
        last_pc <= result.pc;
      end
    end
  end

  // The receiver pops at random. A new hold ticket makes it stop popping for a
  // long stretch so that the block backs up and raises full.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= 400;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // The run ends here if the block stops answering.
  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one word and returns at the clock edge where it is accepted.
  // Must be called at a rising edge; full is looked at on falling edges only.
  task automatic send(input in_t w);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // Waits until every word pushed so far has come back.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (words_popped != words_pushed) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic in_t noise();
    in_t w;
    w = in_t'({$urandom, $urandom});
    return w;
  endfunction

  function automatic in_t mem_write(input logic [15:0] addr, input logic [15:0] d);
    in_t w;
    w = noise();
    w.action = ACT_WRITE;
    w.address = addr;
    w.data = d;
    return w;
  endfunction

  function automatic in_t with_action(input kind_t k);
    in_t w;
    w = noise();
    w.action = k;
    return w;
  endfunction

  // Places an instruction and its immediate at the current PC, optionally
  // mixes in unrelated words, and then executes it.
  task automatic run_ins(input op_t op, input logic [3:0] x, input logic [3:0] y,
                         input logic [3:0] z, input logic [15:0] imm, input bit extras);
    logic [15:0] pc, addr;
    in_t         w;
    drain();
    pc = last_pc;
    send(mem_write(pc, {op, x, y, z}));
    send(mem_write(pc + 16'd1, imm));
    if (extras) begin
      repeat ($urandom_range(2)) begin
        case ($urandom_range(9))
          0: send(with_action(ACT_NONE));
          1, 2, 3, 4: send(with_action(ACT_READ));
          default: begin
            addr = 16'($urandom);
            // Leave the instruction and its immediate untouched.
            if (addr == pc || addr == pc + 16'd1) addr = pc + 16'd2;
            send(mem_write(addr, 16'($urandom)));
          end
        endcase
      end
    end
    send(with_action(ACT_EXEC));
  endtask

  // Loads a register with a constant: r = imm | imm.
  task automatic set_reg(input logic [3:0] r, input logic [15:0] v);
    run_ins(OP_OR, r, IMM_REG, IMM_REG, v, 0);
  endtask

  // One random instruction whose effect on the PC stays known without
  // knowing the register contents: jumps and PC writes take their target
  // from two copies of the immediate, and the PC keeps clear of zero.
  task automatic random_ins();
    op_t         op;
    logic [3:0]  x, y, z;
    logic [15:0] imm;
    op = op_t'($urandom_range(15));
    x = 4'($urandom);
    y = 4'($urandom);
    z = 4'($urandom);
    imm = 16'($urandom);
    if (last_pc >= 16'hff00) begin
      op = OP_BNZ;
      x = IMM_REG;
    end
    if (op == OP_BNZ) begin
      y = IMM_REG;
      z = IMM_REG;
      imm = 16'($urandom_range(16'h77ff, 1));
    end else if (x == PC_REG && op != OP_STORE && op != OP_PRINT) begin
      if ($urandom_range(3) == 0) begin
        op = OP_ADD;
        y = IMM_REG;
        z = IMM_REG;
        imm = 16'($urandom_range(16'h77ff, 1));
      end else begin
        x = 4'd13;
      end
    end
    run_ins(op, x, y, z, imm, 1);
  endtask

  initial begin
    in_t rd_pc;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    words_sent = 0;
    hold_ticket = 0;
    send_idle = 18;
    recv_idle = 63;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: signed divide overflow, divide by zero, shifts by a
    // count far past the width, a write to the PC, the unused action and a
    // read of the PC.
    set_reg(4'd1, 16'h8000);
    set_reg(4'd2, 16'hffff);
    run_ins(OP_DIV, 4'd3, 4'd1, 4'd2, 16'h0000, 0);
    run_ins(OP_DIV, 4'd4, 4'd1, 4'd0, 16'h0000, 0);
    run_ins(OP_SAR, 4'd5, 4'd1, LINK_REG, 16'h0000, 0);
    run_ins(OP_SHL, 4'd6, 4'd2, LINK_REG, 16'h0000, 0);
    run_ins(OP_ADD, PC_REG, IMM_REG, IMM_REG, 16'h0100, 0);
    send(with_action(ACT_NONE));
    rd_pc = with_action(ACT_READ);
    rd_pc.reg_index = PC_REG;
    send(rd_pc);

    // Random part in three idling phases. Early on the receiver holds off
    // while a burst of words keeps coming, so the block fills up.
    while (words_sent < 1400) begin
      if (words_sent >= 940) begin
        send_idle <= 0;
        recv_idle <= 0;
      end else if (words_sent >= 470) begin
        send_idle <= 63;
        recv_idle <= 18;
      end
      if (words_sent >= 200 && hold_ticket == 0) begin
        hold_ticket <= 1;
        repeat (30) begin
          if ($urandom_range(1)) send(mem_write(16'($urandom), 16'($urandom)));
          else send(with_action(ACT_READ));
        end
      end
      random_ins();
    end

    // Branch to address zero: the core halts, further instructions change
    // nothing, while memory writes and register reads still work.
    run_ins(OP_BNZ, IMM_REG, IMM_REG, IMM_REG, 16'h8000, 0);
    send(with_action(ACT_EXEC));
    send(mem_write(16'h0000, {OP_ADD, 4'd1, 4'd2, 4'd3}));
    send(with_action(ACT_EXEC));
    send(with_action(ACT_READ));
    send(with_action(ACT_NONE));

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
